// ===== rtl/heap_sort_engine_macros.svh =====
// ----------------------------------------------------------------------------
// heap sort engine assertion macros
// shared concurrent check forms, sampled on clk and muted during reset
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// same-cycle implication
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// heap sort engine package
// sizes, request and result types, and the compare unit result
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic                    gt;
    logic signed [VAL_W-1:0] larger;
  } cmp_res_t;

endpackage

// ===== rtl/hse_cmp.sv =====
// ----------------------------------------------------------------------------
// heap sort engine compare unit
// signed compare shared by child selection and the sift decision
// ----------------------------------------------------------------------------
module hse_cmp
  import hse_pkg::*;
(
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output cmp_res_t                res
);

  always_comb begin
    res.gt     = (a > b);
    res.larger = (a > b) ? a : b;
  end

endmodule

// ===== rtl/heap_sort_engine.sv =====
// ----------------------------------------------------------------------------
// heap sort engine
// collects a set of signed values and returns them in ascending order
// ----------------------------------------------------------------------------
// Each request is one value; a request flagged last_in closes the set and the
// block stops taking requests until every sorted value has been delivered.
// Values load at one per cycle, and values beyond CAPACITY are dropped.
// The sort runs on a store with one write port and a registered read port, and
// one shared comparator: every level of a sift-down steps through child check,
// left read, right read with child compare (when a right child exists) and
// compare against the sifted value; each root extraction adds fetching the last
// value and moving the root, and each build step adds fetching the value. Each
// result is held until out_stall is low before the next value is read.
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "heap_sort_engine_macros.svh"

  typedef enum logic [3:0] {
    S_LOAD, S_BUILD, S_TGET, S_SIFT, S_RL, S_RR, S_DEC,
    S_EXTR, S_EX_T, S_EX_R, S_OREAD, S_OWAIT, S_OHOLD
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] heap_n_r, heap_n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] hole_r, hole_nxt;
  logic [IDX_W-1:0] bigidx_r, bigidx_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic signed [VAL_W-1:0] t_r, t_nxt;
  logic signed [VAL_W-1:0] lval_r, lval_nxt;
  logic signed [VAL_W-1:0] big_r, big_nxt;
  logic build_r, build_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // sort store
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic [IDX_W-1:0]        mem_ra;
  logic signed [VAL_W-1:0] mem_wd;

  logic signed [VAL_W-1:0] cmp_a;
  logic signed [VAL_W-1:0] cmp_b;
  cmp_res_t                cmp_res;

  logic             store_full;
  logic [CNT_W-1:0] load_cnt;
  logic [CNT_W-1:0] i_m1;
  logic [CNT_W-1:0] hn_m1;
  logic [CH_W-1:0]  child_w;
  logic [CH_W-1:0]  right_w;
  logic             k_last;

  hse_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign store_full = (count_r == CNT_W'(CAPACITY));
  assign load_cnt   = store_full ? count_r : count_r + 1'b1;
  assign i_m1       = i_r - 1'b1;
  assign hn_m1      = heap_n_r - 1'b1;
  assign child_w    = {1'b0, hole_r, 1'b1};
  assign right_w    = child_w + 1'b1;
  assign k_last     = ((CNT_W'(k_r) + 1'b1) == count_r);

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    heap_n_nxt    = heap_n_r;
    i_nxt         = i_r;
    hole_nxt      = hole_r;
    bigidx_nxt    = bigidx_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    lval_nxt      = lval_r;
    big_nxt       = big_r;
    build_nxt     = build_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = hole_r;
    mem_wd        = t_r;
    mem_ra        = hole_r;
    cmp_a         = rd_data_r;
    cmp_b         = lval_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (!store_full) begin
            mem_we = 1'b1;
            mem_wa = count_r[IDX_W-1:0];
            mem_wd = in_data.value;
          end
          count_nxt = load_cnt;
          if (in_data.last_in) begin
            heap_n_nxt = load_cnt;
            i_nxt      = load_cnt >> 1;
            build_nxt  = 1'b1;
            state_nxt  = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        if (i_r == '0) begin
          build_nxt = 1'b0;
          state_nxt = S_EXTR;
        end else begin
          mem_ra    = i_m1[IDX_W-1:0];
          hole_nxt  = i_m1[IDX_W-1:0];
          i_nxt     = i_m1;
          state_nxt = S_TGET;
        end
      end
      S_TGET: begin
        t_nxt     = rd_data_r;
        state_nxt = S_SIFT;
      end
      S_SIFT: begin
        if (child_w >= CH_W'(heap_n_r)) begin
          // no child left: the hole takes the sifted value
          mem_we    = 1'b1;
          state_nxt = build_r ? S_BUILD : S_EXTR;
        end else begin
          mem_ra    = child_w[IDX_W-1:0];
          state_nxt = S_RL;
        end
      end
      S_RL: begin
        lval_nxt = rd_data_r;
        if (right_w < CH_W'(heap_n_r)) begin
          mem_ra    = right_w[IDX_W-1:0];
          state_nxt = S_RR;
        end else begin
          big_nxt    = rd_data_r;
          bigidx_nxt = child_w[IDX_W-1:0];
          state_nxt  = S_DEC;
        end
      end
      S_RR: begin
        big_nxt    = cmp_res.larger;
        bigidx_nxt = cmp_res.gt ? right_w[IDX_W-1:0] : child_w[IDX_W-1:0];
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        cmp_a  = big_r;
        cmp_b  = t_r;
        mem_we = 1'b1;
        if (cmp_res.gt) begin
          mem_wd    = big_r;
          hole_nxt  = bigidx_r;
          state_nxt = S_SIFT;
        end else begin
          state_nxt = build_r ? S_BUILD : S_EXTR;
        end
      end
      S_EXTR: begin
        if (heap_n_r <= CNT_W'(1)) begin
          k_nxt     = '0;
          state_nxt = S_OREAD;
        end else begin
          heap_n_nxt = hn_m1;
          mem_ra     = hn_m1[IDX_W-1:0];
          state_nxt  = S_EX_T;
        end
      end
      S_EX_T: begin
        t_nxt     = rd_data_r;
        mem_ra    = '0;
        state_nxt = S_EX_R;
      end
      S_EX_R: begin
        // root moves to the end of the shrunken heap
        mem_we    = 1'b1;
        mem_wa    = heap_n_r[IDX_W-1:0];
        mem_wd    = rd_data_r;
        hole_nxt  = '0;
        state_nxt = S_SIFT;
      end
      S_OREAD: begin
        mem_ra    = k_r;
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.sorted_value = rd_data_r;
        out_data_nxt.last_out     = k_last;
        state_nxt                 = S_OHOLD;
      end
      S_OHOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (k_last) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_OREAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
    heap_n_r   <= heap_n_nxt;
    i_r        <= i_nxt;
    hole_r     <= hole_nxt;
    bigidx_r   <= bigidx_nxt;
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    lval_r     <= lval_nxt;
    big_r      <= big_nxt;
    out_data_r <= out_data_nxt;
  end

  `HSE_ASSERT_IMP(a_out_only_hold, out_valid_r, state_r == S_OHOLD, "result shown outside hold")
  `HSE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `HSE_ASSERT_NXT(a_load_count, in_valid && !in_stall && !in_data.last_in && !store_full, count_r == $past(count_r) + 1'b1, "stored request not counted")
  `HSE_ASSERT_IMP(a_heap_bound, state_r != S_LOAD, heap_n_r <= count_r && heap_n_r != '0, "heap size out of range")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// heap sort engine testbench
// feeds sets of signed values, predicts the ascending order of each set and
// checks every returned value and its last flag against that prediction
// ----------------------------------------------------------------------------
module tb;
  import hse_pkg::*;

  localparam int          DIR_N       = 22;
  localparam int          RAND_ITEMS  = 450;
  localparam int          DRAIN       = 1500;
  localparam int          HOLD_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum int unsigned {
    FILL_NOISE,
    FILL_DUPS,
    FILL_RISING,
    FILL_FALLING
  } fill_pat_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    bit                      last;
    bit                      typed;
    logic signed [VAL_W-1:0] typed_value;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic                    long_hold   = 1'b0;
  int unsigned             stall_left  = 0;
  int unsigned             results_seen = 0;
  int unsigned             err_count   = 0;
  int unsigned             cycle_count = 0;
  logic signed [VAL_W-1:0] held_vals [CAPACITY];
  int unsigned             held_count  = 0;
  out_item_t               due_sorted [$];

  // single-value sets and extremes carry their result typed in
  dir_row_t dir_rows [DIR_N] = '{
    '{ 32767, 1'b1, 1'b1,  32767},
    '{-32768, 1'b1, 1'b1, -32768},
    '{     0, 1'b1, 1'b1,      0},
    '{    -1, 1'b1, 1'b1,     -1},
    '{ 21845, 1'b0, 1'b0,      0},
    '{-21846, 1'b1, 1'b0,      0},
    '{     7, 1'b0, 1'b0,      0},
    '{     7, 1'b0, 1'b0,      0},
    '{    -3, 1'b0, 1'b0,      0},
    '{     7, 1'b1, 1'b0,      0},
    '{ 32767, 1'b0, 1'b0,      0},
    '{-32768, 1'b0, 1'b0,      0},
    '{     0, 1'b0, 1'b0,      0},
    '{    -1, 1'b1, 1'b0,      0},
    '{   100, 1'b0, 1'b0,      0},
    '{    50, 1'b0, 1'b0,      0},
    '{     0, 1'b0, 1'b0,      0},
    '{   -50, 1'b0, 1'b0,      0},
    '{  -100, 1'b1, 1'b0,      0},
    '{-32768, 1'b0, 1'b0,      0},
    '{-32768, 1'b1, 1'b0,      0},
    '{ 12345, 1'b1, 1'b1,  12345}
  };

  heap_sort_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // move value t down from hole inside a max-heap of n entries
  function automatic void sift_hole(input int unsigned start, input int unsigned n,
                                    input logic signed [VAL_W-1:0] t);
    int unsigned hole;
    int unsigned child;
    bit          settled;
    hole    = start;
    child   = 2 * hole + 1;
    settled = 1'b0;
    while (child < n && !settled) begin
      if (child + 1 < n && held_vals[child+1] > held_vals[child]) child++;
      if (held_vals[child] > t) begin
        held_vals[hole] = held_vals[child];
        hole  = child;
        child = 2 * hole + 1;
      end else begin
        settled = 1'b1;
      end
    end
    held_vals[hole] = t;
  endfunction

  function automatic void absorb_value(input in_item_t req, input bit typed,
                                       input logic signed [VAL_W-1:0] typed_value);
    int unsigned             n;
    int unsigned             i;
    logic signed [VAL_W-1:0] t;
    out_item_t               res;
    // a full store drops the value, even one that closes the set
    if (held_count < CAPACITY) begin
      held_vals[held_count] = req.value;
      held_count++;
    end
    if (req.last_in) begin
      n = held_count;
      for (i = n / 2; i > 0; i--) sift_hole(i - 1, n, held_vals[i-1]);
      while (n > 1) begin
        n--;
        t = held_vals[n];
        held_vals[n] = held_vals[0];
        sift_hole(0, n, t);
      end
      if (typed) begin
        res.sorted_value = typed_value;
        res.last_out     = 1'b1;
        due_sorted.push_back(res);
      end else begin
        for (i = 0; i < held_count; i++) begin
          res.sorted_value = held_vals[i];
          res.last_out     = (i + 1 == held_count);
          due_sorted.push_back(res);
        end
      end
      held_count = 0;
    end
  endfunction

  task automatic offer(input in_item_t req, input int unsigned gap, input bit typed,
                       input logic signed [VAL_W-1:0] typed_value);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_value(req, typed, typed_value);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input fill_pat_t pat,
                                                          input int unsigned k,
                                                          input logic signed [VAL_W-1:0] base,
                                                          input int unsigned step);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    case (pat)
      FILL_DUPS:    return VAL_W'($urandom_range(0, 6) - 3);
      FILL_RISING:  return base + VAL_W'(k * step);
      FILL_FALLING: return base - VAL_W'(k * step);
      default:      return VAL_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int unsigned             i;
    int unsigned             k;
    int unsigned             set_len;
    int unsigned             sent;
    int unsigned             sets;
    int unsigned             step;
    int unsigned             r;
    fill_pat_t               pat;
    logic signed [VAL_W-1:0] base;
    bit                      burst;
    in_item_t                req;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      req.value   = dir_rows[i].value;
      req.last_in = dir_rows[i].last;
      offer(req, $urandom_range(0, 13), dir_rows[i].typed, dir_rows[i].typed_value);
    end

    sent = 0;
    sets = 0;
    while (sent < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (sets == 0) set_len = CAPACITY + 1;      // closing request lands on a full store
      else if (sets == 1) set_len = CAPACITY;
      else if (r < 60) set_len = $urandom_range(1, 6);
      else if (r < 85) set_len = $urandom_range(7, 20);
      else if (r < 95) set_len = $urandom_range(21, CAPACITY);
      else set_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      pat   = fill_pat_t'($urandom_range(0, 3));
      base  = VAL_W'($urandom());
      step  = $urandom_range(0, 700);
      burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < set_len; k++) begin
        req.value   = pick_value(pat, k, base, step);
        req.last_in = (k + 1 == set_len);
        offer(req, burst ? 0 : $urandom_range(0, 13), 1'b0, '0);
      end
      sent += set_len;
      sets++;
    end
    in_valid <= 1'b0;

    while (due_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check each accepted result and draw the next stall
  always @(posedge clk) begin : sink
    int unsigned n;
    out_item_t   want;
    bit          sink_burst;
    if (rst_n) begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        if (due_sorted.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending",
                                    out_data.sorted_value));
        end else begin
          want = due_sorted.pop_front();
          if (out_data.sorted_value !== want.sorted_value)
            report_mismatch($sformatf("sorted_value %0d, wanted %0d",
                                      out_data.sorted_value, want.sorted_value));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %0b, wanted %0b",
                                      out_data.last_out, want.last_out));
        end
        results_seen++;
        if (out_data.last_out) sink_burst = ($urandom_range(0, 3) == 0);
        n = sink_burst ? 0 : $urandom_range(0, 13);
      end
      out_stall  <= long_hold || (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end
  end

  // long hold-off on the result side while requests keep coming
  initial begin : hold_off
    wait (results_seen >= 40);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_cmp.sv
rtl/heap_sort_engine.sv
dv/tb.sv
